// ----- hdl/ght_pkg.sv -----
// ----------------------------------------------------------------------------
// Generational handle table package
// Shared constants, request and status codes, and control structs.
// ----------------------------------------------------------------------------
package ght_pkg;

   // Handle layout: generation in the upper bits, slot+1 in the lower bits.
   localparam int INDEX_BITS  = 20;
   localparam int HANDLE_BITS = 32;
   localparam int GEN_BITS    = HANDLE_BITS - INDEX_BITS;
   localparam int PAYLOAD_BITS = 32;

   localparam logic [INDEX_BITS-1:0] INDEX_MASK = {INDEX_BITS{1'b1}};
   localparam logic [GEN_BITS-1:0]   GEN_MAX    = {GEN_BITS{1'b1}};
   localparam logic [GEN_BITS-1:0]   GEN_FIRST  = GEN_BITS'(1);

   // Default number of slots in the table.
   localparam int DEFAULT_SLOTS = 256;

   // Request codes.
   localparam logic [1:0] REQ_CREATE = 2'd0;
   localparam logic [1:0] REQ_LOOKUP = 2'd1;
   localparam logic [1:0] REQ_REMOVE = 2'd2;

   // Response status codes.
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_BAD  = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic commit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic rsp_free;
   } stat_type;

endpackage

// ----- hdl/ght_ctrl.sv -----
// ----------------------------------------------------------------------------
// Generational handle table controller
// Two-state sequencer: capture an item and read the tables, then commit the
// writeback and load the response register.
// ----------------------------------------------------------------------------
module ght_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  ght_pkg::stat_type stat,
   output ght_pkg::cmd_type  cmd,
   output logic              busy
);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state: leave execute only once the response register can take the item.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (stat.rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Commands follow the current state directly.
   assign cmd.capture = (state_ff == S_IDLE) && req_valid;
   assign cmd.commit  = (state_ff == S_EXEC) && stat.rsp_free;
   assign busy        = (state_ff != S_IDLE);

endmodule

// ----- hdl/ght_datapath.sv -----
// ----------------------------------------------------------------------------
// Generational handle table datapath
// Entry memory, free slot stack, fill and stack counters, and the response
// register.
// ----------------------------------------------------------------------------
module ght_datapath #(
   parameter int SLOTS = ght_pkg::DEFAULT_SLOTS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  ght_pkg::cmd_type                 cmd,
   output ght_pkg::stat_type                stat,
   input  logic [1:0]                       req_type,
   input  logic [ght_pkg::HANDLE_BITS-1:0]  req_handle_word,
   input  logic [ght_pkg::PAYLOAD_BITS-1:0] req_payload_in,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [1:0]                       rsp_status,
   output logic [ght_pkg::HANDLE_BITS-1:0]  rsp_handle_out,
   output logic [ght_pkg::PAYLOAD_BITS-1:0] rsp_payload_out
);

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int IB     = ght_pkg::INDEX_BITS;
   localparam int GB     = ght_pkg::GEN_BITS;
   localparam int PB     = ght_pkg::PAYLOAD_BITS;
   localparam int HB     = ght_pkg::HANDLE_BITS;
   localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

   // Entry memory and free stack. A stack entry carries the slot and the
   // generation it had when it was freed.
   logic [PB-1:0]     ent_payload_mem [SLOTS];
   logic [GB-1:0]     ent_gen_mem     [SLOTS];
   logic              ent_occ_mem     [SLOTS];
   logic [SLOT_W-1:0] stk_slot_mem    [SLOTS];
   logic [GB-1:0]     stk_gen_mem     [SLOTS];

   // Counters.
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] depth_ff, depth_in;

   // Captured item and registered memory reads.
   logic [1:0]        op_ff;
   logic [HB-1:0]     handle_ff;
   logic [PB-1:0]     payload_ff;
   logic [PB-1:0]     ent_payload_rd_ff;
   logic [GB-1:0]     ent_gen_rd_ff;
   logic              ent_occ_rd_ff;
   logic [SLOT_W-1:0] stk_slot_rd_ff;
   logic [GB-1:0]     stk_gen_rd_ff;

   // Response register.
   logic          rsp_valid_ff;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [HB-1:0] rsp_handle_ff, rsp_handle_in;
   logic [PB-1:0] rsp_payload_ff, rsp_payload_in;

   // Read addresses at capture time.
   logic [IB-1:0]     cap_slot_full;
   logic [SLOT_W-1:0] cap_addr;
   logic [CNT_W-1:0]  depth_dec;

   assign cap_slot_full = req_handle_word[IB-1:0] - IB'(1);
   assign cap_addr      = cap_slot_full[SLOT_W-1:0];
   assign depth_dec     = depth_ff - CNT_W'(1);

   // Capture the item and read the entry and the stack top.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff             <= req_type;
         handle_ff         <= req_handle_word;
         payload_ff        <= req_payload_in;
         ent_payload_rd_ff <= ent_payload_mem[cap_addr];
         ent_gen_rd_ff     <= ent_gen_mem[cap_addr];
         ent_occ_rd_ff     <= ent_occ_mem[cap_addr];
         stk_slot_rd_ff    <= stk_slot_mem[depth_dec[SLOT_W-1:0]];
         stk_gen_rd_ff     <= stk_gen_mem[depth_dec[SLOT_W-1:0]];
      end
   end

   // Handle check and writeback decisions.
   logic [IB-1:0]     h_low;
   logic [GB-1:0]     h_gen;
   logic [IB-1:0]     h_slot_full;
   logic              handle_ok;
   logic [GB-1:0]     pop_gen;
   logic              ent_we;
   logic [SLOT_W-1:0] ent_waddr;
   logic [PB-1:0]     ent_wpayload;
   logic [GB-1:0]     ent_wgen;
   logic              ent_wocc;
   logic              stk_push;

   assign h_low       = handle_ff[IB-1:0];
   assign h_gen       = handle_ff[HB-1:IB];
   assign h_slot_full = h_low - IB'(1);
   assign handle_ok   = (h_low != '0) && (h_gen != '0) &&
                        (h_slot_full < IB'(count_ff)) &&
                        ent_occ_rd_ff && (ent_gen_rd_ff == h_gen);
   assign pop_gen     = (stk_gen_rd_ff < ght_pkg::GEN_MAX) ?
                        stk_gen_rd_ff + GB'(1) : stk_gen_rd_ff;

   always_comb begin
      count_in       = count_ff;
      depth_in       = depth_ff;
      ent_we         = 1'b0;
      ent_waddr      = h_slot_full[SLOT_W-1:0];
      ent_wpayload   = payload_ff;
      ent_wgen       = ent_gen_rd_ff;
      ent_wocc       = 1'b1;
      stk_push       = 1'b0;
      rsp_status_in  = ght_pkg::ST_BAD;
      rsp_handle_in  = '0;
      rsp_payload_in = '0;
      case (op_ff)
         ght_pkg::REQ_CREATE: begin
            if (depth_ff != '0) begin
               // Reuse the most recently freed slot.
               depth_in      = depth_dec;
               ent_we        = 1'b1;
               ent_waddr     = stk_slot_rd_ff;
               ent_wgen      = pop_gen;
               rsp_status_in = ght_pkg::ST_OK;
               rsp_handle_in = {pop_gen, IB'(stk_slot_rd_ff) + IB'(1)};
            end else if (count_ff < SLOTS_CNT) begin
               // Take the next slot that was never used.
               count_in      = count_ff + CNT_W'(1);
               ent_we        = 1'b1;
               ent_waddr     = count_ff[SLOT_W-1:0];
               ent_wgen      = ght_pkg::GEN_FIRST;
               rsp_status_in = ght_pkg::ST_OK;
               rsp_handle_in = {ght_pkg::GEN_FIRST, IB'(count_ff) + IB'(1)};
            end else begin
               rsp_status_in = ght_pkg::ST_FULL;
            end
         end
         ght_pkg::REQ_LOOKUP: begin
            if (handle_ok) begin
               rsp_status_in  = ght_pkg::ST_OK;
               rsp_payload_in = ent_payload_rd_ff;
            end
         end
         ght_pkg::REQ_REMOVE: begin
            if (handle_ok) begin
               rsp_status_in  = ght_pkg::ST_OK;
               rsp_payload_in = ent_payload_rd_ff;
               ent_we         = 1'b1;
               ent_wpayload   = '0;
               ent_wocc       = 1'b0;
               // A slot whose generation has saturated is retired.
               if ((ent_gen_rd_ff < ght_pkg::GEN_MAX) && (depth_ff < SLOTS_CNT)) begin
                  stk_push = 1'b1;
                  depth_in = depth_ff + CNT_W'(1);
               end
            end
         end
         default: begin
            rsp_status_in = ght_pkg::ST_BAD;
         end
      endcase
   end

   // Memory writes at commit.
   always_ff @(posedge clock) begin
      if (cmd.commit && ent_we) begin
         ent_payload_mem[ent_waddr] <= ent_wpayload;
         ent_gen_mem[ent_waddr]     <= ent_wgen;
         ent_occ_mem[ent_waddr]     <= ent_wocc;
      end
      if (cmd.commit && stk_push) begin
         stk_slot_mem[depth_ff[SLOT_W-1:0]] <= h_slot_full[SLOT_W-1:0];
         stk_gen_mem[depth_ff[SLOT_W-1:0]]  <= ent_gen_rd_ff;
      end
   end

   // Counters and response valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            count_ff     <= count_in;
            depth_ff     <= depth_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_handle_ff  <= rsp_handle_in;
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign stat.rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_handle_out  = rsp_handle_ff;
   assign rsp_payload_out = rsp_payload_ff;

endmodule

// ----- hdl/generational_handle_table.sv -----
// ----------------------------------------------------------------------------
// Generational handle table
// Creates, looks up and removes entries addressed by packed handles that
// carry a generation count, reusing freed slots last in, first out.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | fields
//   req     | in        | req_valid, req_stall | req_type, handle_word, payload_in
//   rsp     | out       | rsp_valid, rsp_stall | status, handle_out, payload_out
//
// For each item, the accept edge reads the entry memory and the free stack
// top into registers; the commit in the execute state then writes back and loads
// the response register. A new item is read only after the last one has been
// written back, so no forwarding is needed between items.
// Reset clears the fill count, the free stack depth and the response valid;
// the memories need no clearing pass.
// A stalled response holds the block in its write-back cycle until the
// response register frees; a new item is accepted while a response waits.
//
module generational_handle_table #(
   parameter int SLOTS = ght_pkg::DEFAULT_SLOTS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_type,
   input  logic [ght_pkg::HANDLE_BITS-1:0]  req_handle_word,
   input  logic [ght_pkg::PAYLOAD_BITS-1:0] req_payload_in,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [1:0]                       rsp_status,
   output logic [ght_pkg::HANDLE_BITS-1:0]  rsp_handle_out,
   output logic [ght_pkg::PAYLOAD_BITS-1:0] rsp_payload_out
);

   ght_pkg::cmd_type  cmd;
   ght_pkg::stat_type stat;
   logic              busy;

   // Sequencer.
   ght_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy)
   );

   // Tables, counters and response register.
   ght_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_type        (req_type),
      .req_handle_word (req_handle_word),
      .req_payload_in  (req_payload_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_handle_out  (rsp_handle_out),
      .rsp_payload_out (rsp_payload_out)
   );

   assign req_stall = busy;

   // The block is busy in the cycle after an accepted item.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("block not busy after accepting an item");

   // A response appears only from a commit of the sequencer.
   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.commit))
      else $error("response without commit");

   // A failed item returns zero handle and zero payload.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ght_pkg::ST_OK)) |->
      ((rsp_handle_out == '0) && (rsp_payload_out == '0)))
      else $error("failed response carries data");

endmodule

// ----- verif/generational_handle_table_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Generational handle table checker
// Watches the request and response channels, keeps its own copy of the
// table, the generation counters and the free stack, and compares every
// accepted response field by field with the oldest predicted response.
// ----------------------------------------------------------------------------
module generational_handle_table_checker #(
   parameter int SLOTS = ght_pkg::DEFAULT_SLOTS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic [1:0]                       req_type,
   input  logic [ght_pkg::HANDLE_BITS-1:0]  req_handle_word,
   input  logic [ght_pkg::PAYLOAD_BITS-1:0] req_payload_in,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic [1:0]                       rsp_status,
   input  logic [ght_pkg::HANDLE_BITS-1:0]  rsp_handle_out,
   input  logic [ght_pkg::PAYLOAD_BITS-1:0] rsp_payload_out,
   output int                               fail_count,
   output int                               results_owed
);

   typedef struct packed {
      logic [1:0]                       status;
      logic [ght_pkg::HANDLE_BITS-1:0]  handle;
      logic [ght_pkg::PAYLOAD_BITS-1:0] payload;
   } table_response_type;

   // Shadow copy of the table.
   logic [ght_pkg::PAYLOAD_BITS-1:0] slot_payload [SLOTS];
   logic [ght_pkg::GEN_BITS-1:0]     slot_gen [SLOTS];
   bit                               slot_live [SLOTS];
   int unsigned                      slots_taken;
   int unsigned                      free_slots [$];

   table_response_type pending_responses [$];
   int                 mismatches = 0;

   assign fail_count = mismatches;

   // A handle names a live entry when both fields are nonzero, the slot has
   // been taken into use, it is occupied and the generations agree.
   function automatic bit locate_entry(input logic [ght_pkg::HANDLE_BITS-1:0] hw,
                                       output int unsigned slot);
      logic [ght_pkg::INDEX_BITS-1:0] index_field;
      logic [ght_pkg::GEN_BITS-1:0]   gen_field;
      index_field = hw[ght_pkg::INDEX_BITS-1:0];
      gen_field   = hw[ght_pkg::HANDLE_BITS-1:ght_pkg::INDEX_BITS];
      slot        = 0;
      if (index_field == '0 || gen_field == '0) return 1'b0;
      slot = 32'(index_field - 1'b1);
      if (slot >= slots_taken || slot >= SLOTS) return 1'b0;
      return slot_live[slot] && slot_gen[slot] == gen_field;
   endfunction

   // Works out the response to one request and updates the shadow table.
   function automatic table_response_type apply_request(input logic [1:0] kind,
         input logic [ght_pkg::HANDLE_BITS-1:0] hw,
         input logic [ght_pkg::PAYLOAD_BITS-1:0] pw);
      table_response_type r;
      int unsigned        slot;
      bit                 got;
      r   = '{status: ght_pkg::ST_BAD, handle: '0, payload: '0};
      got = 1'b0;
      case (kind)
         ght_pkg::REQ_CREATE: begin
            // Most recently freed slot first, then a never-used one.
            if (free_slots.size() != 0) begin
               slot = free_slots[$];
               free_slots.delete(free_slots.size() - 1);
               if (slot_gen[slot] != ght_pkg::GEN_MAX)
                  slot_gen[slot] = slot_gen[slot] + 1'b1;
               got = 1'b1;
            end else if (slots_taken < SLOTS) begin
               slot = slots_taken;
               slots_taken++;
               slot_gen[slot] = ght_pkg::GEN_FIRST;
               got = 1'b1;
            end
            if (got) begin
               slot_payload[slot] = pw;
               slot_live[slot]    = 1'b1;
               r.status = ght_pkg::ST_OK;
               r.handle = {slot_gen[slot], ght_pkg::INDEX_BITS'(slot + 1)};
            end else begin
               r.status = ght_pkg::ST_FULL;
            end
         end
         ght_pkg::REQ_LOOKUP: begin
            if (locate_entry(hw, slot)) begin
               r.status  = ght_pkg::ST_OK;
               r.payload = slot_payload[slot];
            end
         end
         ght_pkg::REQ_REMOVE: begin
            if (locate_entry(hw, slot)) begin
               r.status  = ght_pkg::ST_OK;
               r.payload = slot_payload[slot];
               slot_payload[slot] = '0;
               slot_live[slot]    = 1'b0;
               // A saturated slot is retired instead of freed.
               if (slot_gen[slot] != ght_pkg::GEN_MAX && free_slots.size() < SLOTS)
                  free_slots.insert(free_slots.size(), slot);
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // Responses are checked before the request of the same edge is predicted,
   // since a response never belongs to an item accepted at the same edge.
   always @(posedge clock) begin : watch
      table_response_type want;
      if (reset) begin
         slots_taken = 0;
         free_slots.delete();
         pending_responses.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_responses.size() == 0) begin
               $error("unexpected response item: status %0d, handle_out %h, payload_out %h",
                      rsp_status, rsp_handle_out, rsp_payload_out);
               mismatches++;
            end else begin
               want = pending_responses.pop_front();
               if (rsp_status !== want.status) begin
                  $error("rsp_status: expected %0d, actual %0d", want.status, rsp_status);
                  mismatches++;
               end
               if (rsp_handle_out !== want.handle) begin
                  $error("rsp_handle_out: expected %h, actual %h", want.handle,
                         rsp_handle_out);
                  mismatches++;
               end
               if (rsp_payload_out !== want.payload) begin
                  $error("rsp_payload_out: expected %h, actual %h", want.payload,
                         rsp_payload_out);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall)
            pending_responses.insert(pending_responses.size(),
                                     apply_request(req_type, req_handle_word,
                                                   req_payload_in));
      end
      results_owed <= pending_responses.size();
   end

endmodule

// ----- verif/generational_handle_table_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Generational handle table testbench
// Drives directed and random create, lookup and remove items, including a
// create and remove loop that reuses one slot many times over, under varying
// sender gaps and receiver stalls. The checker beside the block predicts and
// compares every response.
// ----------------------------------------------------------------------------
module generational_handle_table_tb;

   localparam int          CLOCK_PERIOD   = 12;
   localparam int          TIMEOUT_CYCLES = 1_500_000;
   localparam int          RECYCLE_ROUNDS = 40;
   localparam logic [1:0]  REQ_UNUSED     = 2'd3;

   logic                             clock;
   logic                             reset           = 1'b1;
   logic                             req_valid       = 1'b0;
   logic                             req_stall;
   logic [1:0]                       req_type        = ght_pkg::REQ_CREATE;
   logic [ght_pkg::HANDLE_BITS-1:0]  req_handle_word = '0;
   logic [ght_pkg::PAYLOAD_BITS-1:0] req_payload_in  = '0;
   logic                             rsp_valid;
   logic                             rsp_stall       = 1'b0;
   logic [1:0]                       rsp_status;
   logic [ght_pkg::HANDLE_BITS-1:0]  rsp_handle_out;
   logic [ght_pkg::PAYLOAD_BITS-1:0] rsp_payload_out;

   int fail_count;
   int results_owed;
   int send_idle_pct = 11;
   int stall_pct     = 70;

   // Handles returned by successful creates, used to build valid requests.
   logic [ght_pkg::HANDLE_BITS-1:0] live_handles [$];

   generational_handle_table dut (.*);

   generational_handle_table_checker checker_inst (.*);

   always begin
      clock = 1'b0;
      #(CLOCK_PERIOD / 2);
      clock = 1'b1;
      #(CLOCK_PERIOD / 2);
   end

   // Random receiver stalls.
   always @(posedge clock)
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);

   // Collect every handle the block hands out.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall && rsp_status == ght_pkg::ST_OK &&
          rsp_handle_out != '0)
         live_handles.insert(live_handles.size(), rsp_handle_out);
   end

   // Offers one item, with an occasional gap first, and returns at the edge
   // that accepts it.
   task automatic send_item(input logic [1:0] kind,
                            input logic [ght_pkg::HANDLE_BITS-1:0] hw,
                            input logic [ght_pkg::PAYLOAD_BITS-1:0] pw);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_handle_word <= hw;
      req_payload_in  <= pw;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Holds the sender back until every predicted response has arrived.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
   endtask

   // Random mix: creates at the given rate, the rest valid lookups and
   // removes, near-miss handles and plain noise.
   task automatic send_mix(input int count, input int create_pct);
      int                              pick;
      int                              idx;
      logic [ght_pkg::HANDLE_BITS-1:0] hw;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         idx  = (live_handles.size() != 0) ? $urandom_range(0, live_handles.size() - 1) : 0;
         hw   = $urandom;
         if (pick < create_pct) begin
            send_item(ght_pkg::REQ_CREATE, hw, $urandom);
         end else begin
            pick = $urandom_range(0, 99);
            if (live_handles.size() == 0 || pick >= 90) begin
               if ($urandom_range(0, 1))
                  hw[ght_pkg::INDEX_BITS-1:0] = ght_pkg::INDEX_BITS'($urandom_range(0, 300));
               send_item(2'($urandom_range(0, 3)), hw, $urandom);
            end else if (pick < 35) begin
               send_item(ght_pkg::REQ_LOOKUP, live_handles[idx], $urandom);
            end else if (pick < 75) begin
               hw = live_handles[idx];
               live_handles.delete(idx);
               send_item(ght_pkg::REQ_REMOVE, hw, $urandom);
            end else begin
               // Near miss: neighboring generation or neighboring slot.
               hw = live_handles[idx];
               case ($urandom_range(0, 2))
                  0: hw[ght_pkg::HANDLE_BITS-1:ght_pkg::INDEX_BITS] =
                        hw[ght_pkg::HANDLE_BITS-1:ght_pkg::INDEX_BITS] + 1'b1;
                  1: hw[ght_pkg::HANDLE_BITS-1:ght_pkg::INDEX_BITS] =
                        hw[ght_pkg::HANDLE_BITS-1:ght_pkg::INDEX_BITS] - 1'b1;
                  default: hw[ght_pkg::INDEX_BITS-1:0] = hw[ght_pkg::INDEX_BITS-1:0] + 1'b1;
               endcase
               send_item($urandom_range(0, 1) ? ght_pkg::REQ_LOOKUP : ght_pkg::REQ_REMOVE,
                         hw, $urandom);
            end
         end
      end
   endtask

   // Removes and recreates one slot a number of times, so that each create
   // reuses it with the next generation, then probes the stale handle.
   task automatic recycle_one_slot();
      logic [ght_pkg::HANDLE_BITS-1:0] hw;
      int                              rounds;
      send_item(ght_pkg::REQ_CREATE, $urandom, $urandom);
      wait_drained();
      if (live_handles.size() != 0) begin
         hw = live_handles[$];
         live_handles.delete(live_handles.size() - 1);
         rounds = 0;
         while (rounds < RECYCLE_ROUNDS) begin
            send_item(ght_pkg::REQ_REMOVE, hw, $urandom);
            send_item(ght_pkg::REQ_CREATE, $urandom, $urandom);
            wait_drained();
            if (live_handles.size() == 0) break;
            hw = live_handles[$];
            live_handles.delete(live_handles.size() - 1);
            rounds++;
         end
         send_item(ght_pkg::REQ_LOOKUP, hw, $urandom);
         send_item(ght_pkg::REQ_REMOVE, hw, $urandom);
         send_item(ght_pkg::REQ_CREATE, $urandom, $urandom);
         send_item(ght_pkg::REQ_LOOKUP, hw, $urandom);
         send_item(ght_pkg::REQ_REMOVE, hw, $urandom);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: bad handles on an empty table, the first creates, stale
      // and mismatched handles, the unused request code and last in, first
      // out reuse.
      send_item(ght_pkg::REQ_LOOKUP, 32'h0, 32'h0);
      send_item(ght_pkg::REQ_REMOVE, {12'd1, 20'd1}, 32'h1234_5678);
      send_item(REQ_UNUSED, {12'd1, 20'd1}, 32'hFFFF_FFFF);
      send_item(ght_pkg::REQ_CREATE, 32'hFFFF_FFFF, 32'h0);
      send_item(ght_pkg::REQ_CREATE, 32'h0, 32'hFFFF_FFFF);
      send_item(ght_pkg::REQ_LOOKUP, {12'd0, 20'd1}, 32'h0);
      send_item(ght_pkg::REQ_LOOKUP, {12'd1, 20'd1}, 32'h0);
      send_item(ght_pkg::REQ_LOOKUP, {12'd1, 20'd2}, 32'h0);
      send_item(ght_pkg::REQ_LOOKUP, {12'd2, 20'd1}, 32'h0);
      send_item(ght_pkg::REQ_LOOKUP, {12'd1, 20'd3}, 32'h0);
      send_item(ght_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0);
      send_item(ght_pkg::REQ_REMOVE, {12'd1, 20'd1}, 32'h0);
      send_item(ght_pkg::REQ_REMOVE, {12'd1, 20'd1}, 32'h0);
      send_item(ght_pkg::REQ_LOOKUP, {12'd1, 20'd1}, 32'h0);
      send_item(ght_pkg::REQ_CREATE, 32'h0, 32'hA5A5_5A5A);
      send_item(REQ_UNUSED, {12'd2, 20'd1}, 32'h0);
      send_item(ght_pkg::REQ_LOOKUP, {12'd2, 20'd1}, 32'h0);
      send_item(ght_pkg::REQ_REMOVE, {12'd1, 20'd2}, 32'h0);
      send_item(ght_pkg::REQ_REMOVE, {12'd2, 20'd1}, 32'h0);
      send_item(ght_pkg::REQ_CREATE, 32'h0, 32'h0F0F_F0F0);
      send_item(ght_pkg::REQ_CREATE, 32'h0, 32'h8000_0001);
      send_item(ght_pkg::REQ_LOOKUP, {12'd3, 20'd1}, 32'h0);
      send_item(ght_pkg::REQ_LOOKUP, {12'd2, 20'd2}, 32'h0);

      // Random: fill past full, then drain, under three idling patterns.
      send_mix(350, 85);
      send_mix(200, 15);

      send_idle_pct = 70;
      stall_pct     = 11;
      send_mix(350, 85);
      send_mix(200, 15);

      send_idle_pct = 0;
      stall_pct     = 0;
      send_mix(350, 85);
      wait_drained();
      recycle_one_slot();
      send_mix(90, 15);

      wait_drained();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && results_owed == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Run limit.
   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("Verification failed");
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/ght_pkg.sv
hdl/ght_ctrl.sv
hdl/ght_datapath.sv
hdl/generational_handle_table.sv
verif/generational_handle_table_checker.sv
verif/generational_handle_table_tb.sv
